[sv/packet_byte_scrambler_unit_assert.svh]
// assertion macros used by the scrambler unit
// they expect clk_i and rst_ni in scope
`ifndef PACKET_BYTE_SCRAMBLER_UNIT_ASSERT_SVH
`define PACKET_BYTE_SCRAMBLER_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define PBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// implication checked in the next cycle, outside reset
`define PBS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

[sv/pbs_pkg.sv]
package pbs_pkg;

  // register indexes on the write port
  typedef enum logic [1:0] {
    CFG_XOR_KEY    = 2'd0,
    CFG_ADD_KEY    = 2'd1,
    CFG_OBF_ENABLE = 2'd2
  } cfg_index_e;

  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = 8;

  localparam logic [7:0] XorKeyReset = 8'hE2;
  localparam logic [7:0] AddKeyReset = 8'h02;
  localparam logic [7:0] LongMark    = 8'hC2;

  localparam int unsigned StartLong  = 4;
  localparam int unsigned StartShort = 3;
  localparam int unsigned TableBits  = 5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] xor_key;
    logic [7:0] add_key;
    logic       obfuscate_enable;
  } cfg_t;

  function automatic logic [7:0] scramble_lookup(input logic [TableBits-1:0] idx);
    logic [7:0] val;
    unique case (idx)
      5'd0:  val = 8'hAB;
      5'd1:  val = 8'h11;
      5'd2:  val = 8'hCD;
      5'd3:  val = 8'hFE;
      5'd4:  val = 8'h18;
      5'd5:  val = 8'h23;
      5'd6:  val = 8'hC5;
      5'd7:  val = 8'hA3;
      5'd8:  val = 8'hCA;
      5'd9:  val = 8'h33;
      5'd10: val = 8'hC1;
      5'd11: val = 8'hCC;
      5'd12: val = 8'h66;
      5'd13: val = 8'h67;
      5'd14: val = 8'h21;
      5'd15: val = 8'hF3;
      5'd16: val = 8'h32;
      5'd17: val = 8'h12;
      5'd18: val = 8'h15;
      5'd19: val = 8'h35;
      5'd20: val = 8'h29;
      5'd21: val = 8'hFF;
      5'd22: val = 8'hFE;
      5'd23: val = 8'h1D;
      5'd24: val = 8'h44;
      5'd25: val = 8'hEF;
      5'd26: val = 8'hCD;
      5'd27: val = 8'h41;
      5'd28: val = 8'h26;
      5'd29: val = 8'h3C;
      5'd30: val = 8'h4E;
      5'd31: val = 8'h4D;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

[sv/packet_byte_scrambler_unit.sv]
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------
// in       | in_valid_i   | in_stall_o   | in_item_i  (in_item_t)
// out      | out_valid_o  | out_stall_i  | out_item_o (out_item_t)
// cfg      | cfg_we_i     | none         | cfg_index_i, cfg_data_i
//
// one item per clock sustained while the output side does not stall; each
// result is registered in the single output register after the scramble
// logic, or first in a skid register that keeps input taken while the output
// side stalls; in_stall_o rises only once both of those registers are full
// reset clears keys to their defaults, enable off and packet state to start

`include "packet_byte_scrambler_unit_assert.svh"

module packet_byte_scrambler_unit import pbs_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_item_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // output register and skid register
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;

  logic      in_accept;
  logic      out_fire;
  out_item_t result;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i & ~skid_valid_q;
  assign out_fire    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // register writes, unknown index ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_XOR_KEY:    cfg_d.xor_key          = cfg_data_i;
        CFG_ADD_KEY:    cfg_d.add_key          = cfg_data_i;
        CFG_OBF_ENABLE: cfg_d.obfuscate_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // scramble state and per-byte logic
  pbs_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_accept),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  // output side: skid drains first, fresh result goes straight out when free
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_fire) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xor_key          <= XorKeyReset;
      cfg_q.add_key          <= AddKeyReset;
      cfg_q.obfuscate_enable <= 1'b0;
      out_valid_q            <= 1'b0;
      skid_valid_q           <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // skid only ever holds an item behind a waiting output
  `PBS_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q)
  // an item taken while the output waits must land in the skid register
  `PBS_ASSERT_NEXT(a_skid_fills, in_accept && out_valid_q && out_stall_i, skid_valid_q)
  // a drained skid register frees the input next cycle
  `PBS_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall_i, !skid_valid_q && out_valid_q)

endmodule

[sv/pbs_core.sv]
module pbs_core import pbs_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [7:0]               prior_q, prior_d;
  logic                     long_q, long_d;

  logic                     is_long;
  logic [POSITION_BITS-1:0] start_pos;
  logic [7:0]               scr;
  logic [7:0]               ciph;

  always_comb begin
    is_long   = (pos_q == '0) ? (item_i.in_byte == LongMark) : long_q;
    start_pos = is_long ? POSITION_BITS'(StartLong) : POSITION_BITS'(StartShort);
    if (pos_q >= start_pos) begin
      scr = item_i.in_byte ^ prior_q ^ scramble_lookup(pos_q[TableBits-1:0]);
    end else begin
      scr = item_i.in_byte;
    end
    // add then xor, both modulo 256
    ciph = (scr + cfg_i.add_key) ^ cfg_i.xor_key;

    result_o.out_byte = cfg_i.obfuscate_enable ? ciph : item_i.in_byte;
    result_o.out_last = item_i.in_last;
  end

  // chain state advances whatever the enable says
  always_comb begin
    pos_d   = pos_q;
    prior_d = prior_q;
    long_d  = long_q;
    if (step_i) begin
      if (item_i.in_last) begin
        pos_d   = '0;
        prior_d = '0;
        long_d  = 1'b0;
      end else begin
        long_d  = is_long;
        prior_d = scr;
        if (pos_q != PosMax) begin
          pos_d = pos_q + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      prior_q <= '0;
      long_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      prior_q <= prior_d;
      long_q  <= long_d;
    end
  end

endmodule

[sim/tb_packet_byte_scrambler_unit.sv]
`timescale 1ns / 1ps

module tb_packet_byte_scrambler_unit;
  import pbs_pkg::*;

  // position counter at the block's own width; long packets carry the
  // position well past the table length and past eight bits
  localparam int unsigned PosBits = 16;

  // register index with no register behind it, writes must be ignored
  localparam logic [CfgIndexBits-1:0] CfgUnusedIndex = 2'd3;

  // per-position scramble constants, entry 0 first
  localparam logic [0:31][7:0] ScrambleTable = {
    8'hAB, 8'h11, 8'hCD, 8'hFE, 8'h18, 8'h23, 8'hC5, 8'hA3,
    8'hCA, 8'h33, 8'hC1, 8'hCC, 8'h66, 8'h67, 8'h21, 8'hF3,
    8'h32, 8'h12, 8'h15, 8'h35, 8'h29, 8'hFF, 8'hFE, 8'h1D,
    8'h44, 8'hEF, 8'hCD, 8'h41, 8'h26, 8'h3C, 8'h4E, 8'h4D
  };

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  in_item_t                in_item_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_item_t               out_item_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0]  cfg_data_i  = '0;

  packet_byte_scrambler_unit #(
    .POSITION_BITS(PosBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 4 ns period
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // shadow copy of the key registers, kept in step with every write
  logic [7:0] xor_key_shadow = XorKeyReset;
  logic [7:0] add_key_shadow = AddKeyReset;
  logic       enable_shadow  = 1'b0;

  // packet tracking state of the predictor
  logic [PosBits-1:0] pkt_position  = '0;
  logic [7:0]         pkt_chain     = '0;
  logic               pkt_long_hdr  = 1'b0;

  in_item_t  pending_bytes[$];    // bytes waiting to be offered
  out_item_t expected_bytes[$];   // predicted output bytes, oldest first
  int unsigned bytes_outstanding = 0;  // queued but not yet seen at the output
  int unsigned idle_pct = 29;
  int unsigned failures = 0;

  // works out the output byte for one accepted input byte and advances the
  // packet state; the chain and position move on whether or not the cipher
  // is enabled
  function automatic out_item_t scramble_predict(input in_item_t item);
    logic        is_long;
    int unsigned start_pos;
    logic [7:0]  scrambled;
    logic [7:0]  enciphered;
    out_item_t   res;
    // the header byte decides the scramble start for the whole packet
    is_long   = (pkt_position == '0) ? (item.in_byte == LongMark) : pkt_long_hdr;
    start_pos = is_long ? StartLong : StartShort;
    if (pkt_position >= start_pos) begin
      scrambled = item.in_byte ^ pkt_chain ^ ScrambleTable[pkt_position[TableBits-1:0]];
    end else begin
      scrambled = item.in_byte;
    end
    enciphered   = 8'(scrambled + add_key_shadow) ^ xor_key_shadow;
    res.out_byte = enable_shadow ? enciphered : item.in_byte;
    res.out_last = item.in_last;
    if (item.in_last) begin
      // end of packet: the next byte is a fresh header
      pkt_position = '0;
      pkt_chain    = '0;
      pkt_long_hdr = 1'b0;
    end else begin
      pkt_long_hdr = is_long;
      pkt_chain    = scrambled;
      // the position sticks at all-ones on very long packets
      if (pkt_position != '1) begin
        pkt_position = pkt_position + 1'b1;
      end
    end
    return res;
  endfunction

  // sender: offers queued bytes, idling at random; a stalled item is held
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_bytes.insert(expected_bytes.size(), scramble_predict(in_item_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_item_i  <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          // junk on the payload while nothing is offered
          in_item_i.in_byte <= 8'($urandom);
          in_item_i.in_last <= 1'($urandom);
          in_valid_i        <= 1'b0;
        end
      end
    end
  end

  // receiver: stalls at random and checks every result against the oldest
  // prediction
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("output byte %02h with no item outstanding", out_item_o.out_byte);
          failures++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_outstanding--;
          if (out_item_o.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.out_byte, out_item_o.out_byte);
            failures++;
          end
          if (out_item_o.out_last !== want.out_last) begin
            $error("out_last mismatch: expected %0b, actual %0b",
                   want.out_last, out_item_o.out_last);
            failures++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] value, input logic last);
    in_item_t item;
    item.in_byte = value;
    item.in_last = last;
    pending_bytes.insert(pending_bytes.size(), item);
    bytes_outstanding++;
  endtask

  // one packet of random content, optionally with the long header mark
  task automatic push_packet(input int unsigned len, input bit long_hdr);
    logic [7:0] value;
    for (int unsigned i = 0; i < len; i++) begin
      value = (i == 0 && long_hdr) ? LongMark : 8'($urandom);
      push_byte(value, i == len - 1);
    end
  endtask

  // waits until every queued byte has come back out
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (bytes_outstanding != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // register write, only ever issued with the block drained
  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_XOR_KEY) begin
      xor_key_shadow = value;
    end else if (idx == CFG_ADD_KEY) begin
      add_key_shadow = value;
    end else if (idx == CFG_OBF_ENABLE) begin
      enable_shadow = value[0];
    end
  endtask

  // configuration for one test phase; enable carries junk in its upper bits
  task automatic write_keys(input logic [7:0] xor_val, input logic [7:0] add_val,
                            input logic en);
    write_reg(CFG_XOR_KEY, xor_val);
    write_reg(CFG_ADD_KEY, add_val);
    write_reg(CFG_OBF_ENABLE, {7'($urandom), en});
  endtask

  initial begin : stimulus
    int unsigned count;
    int unsigned roll;
    int unsigned len;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset keys, cipher off: bytes pass straight through
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hC2, 1'b1);
    wait_drained();

    // reset keys, cipher on: long header, scrambling from the fifth byte
    write_reg(CFG_OBF_ENABLE, 8'h01);
    push_byte(8'hC2, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h3C, 1'b1);
    wait_drained();

    // all-ones keys with a short header, scrambling from the fourth byte
    write_reg(CFG_XOR_KEY, 8'hFF);
    write_reg(CFG_ADD_KEY, 8'hFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b1);
    wait_drained();

    // zero keys, single-byte packets
    write_reg(CFG_XOR_KEY, 8'h00);
    write_reg(CFG_ADD_KEY, 8'h00);
    push_byte(8'hC2, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_drained();

    // cipher switched on in the middle of a packet, sender held until the
    // first half has fully come out; a write to the spare index comes first
    write_reg(CFG_OBF_ENABLE, 8'h00);
    write_reg(CfgUnusedIndex, 8'hFF);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    wait_drained();
    write_reg(CFG_OBF_ENABLE, 8'h01);
    push_byte(8'h44, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h66, 1'b1);
    wait_drained();

    // long packets, the position runs past eight bits
    write_keys(8'($urandom), 8'($urandom), 1'b1);
    push_packet($urandom_range(260, 300), 1'b1);
    push_packet($urandom_range(257, 270), 1'b0);
    wait_drained();

    // random packets over several key settings, extremes first
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_keys(8'h00, 8'hFF, 1'b1);
        1: write_keys(8'hFF, 8'h00, 1'b1);
        2: write_keys(8'($urandom), 8'($urandom), 1'b0);
        default: write_keys(8'($urandom), 8'($urandom), $urandom_range(3) != 0);
      endcase
      // one phase runs flat out on both sides
      idle_pct = (phase == 3) ? 0 : 29;
      count = 0;
      while (count < 65) begin
        roll = $urandom_range(99);
        if (roll < 65) begin
          len = $urandom_range(1, 8);
        end else if (roll < 90) begin
          len = $urandom_range(9, 40);
        end else begin
          // broken packets: a byte or two, header random
          len = $urandom_range(1, 2);
        end
        push_packet(len, $urandom_range(99) < 45);
        count += len;
      end
      wait_drained();
    end
    idle_pct = 29;

    repeat (10) @(posedge clk_i);
    if (failures == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
